// File: rtl/psgt_pkg.sv
// Package for the per-source sequence gap tracker.
// Holds the transfer structs, operation and class codes, and the saturating adder.
// No dependencies.
package psgt_pkg;

  localparam int unsigned NumSourcesDefault = 16;

  typedef enum logic [2:0] {
    OP_ACCEPT        = 3'd0,
    OP_CREDIT        = 3'd1,
    OP_CLEAR_SOURCE  = 3'd2,
    OP_CLEAR_SOURCES = 3'd3,
    OP_CLEAR_ALL     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CLS_FIRST     = 2'd0,
    CLS_IN_ORDER  = 2'd1,
    CLS_GAP       = 2'd2,
    CLS_REORDERED = 2'd3
  } class_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  source_index;
    logic [15:0] sequence_number;
    logic        queue_ok;
  } psgt_in_t;

  typedef struct packed {
    logic [1:0]  frame_class;
    logic [14:0] missing_frames;
    logic        credited;
    logic [31:0] total_frames;
    logic [31:0] total_gap_events;
    logic [31:0] total_gap_frames;
    logic [31:0] total_reordered;
    logic [31:0] total_recovered;
  } psgt_out_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? '1 : sum[31:0];
  endfunction

endpackage

// File: rtl/psgt_track.sv
// Per-source state table and global totals of the sequence gap tracker.
// Classifies one item per cycle and updates the state on exec_i.
// Depends on psgt_pkg.
module psgt_track #(
  parameter int unsigned NumSources = psgt_pkg::NumSourcesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                exec_i,
  input  psgt_pkg::psgt_in_t  item_i,
  output psgt_pkg::psgt_out_t result_o
);
  import psgt_pkg::*;

  localparam int unsigned SrcW = (NumSources > 1) ? $clog2(NumSources) : 1;
  localparam int unsigned IdxW = (SrcW > 4) ? SrcW : 4;

  logic        seen_q [NumSources];
  logic        seen_d [NumSources];
  logic [15:0] last_q [NumSources];
  logic [15:0] last_d [NumSources];
  logic [31:0] pend_q [NumSources];
  logic [31:0] pend_d [NumSources];

  logic [31:0] frames_q, frames_d;
  logic [31:0] gap_events_q, gap_events_d;
  logic [31:0] gap_frames_q, gap_frames_d;
  logic [31:0] reordered_q, reordered_d;
  logic [31:0] recovered_q, recovered_d;

  logic [IdxW-1:0] src_ext;
  logic [SrcW-1:0] idx;
  logic            src_ok;
  logic            cur_seen;
  logic [15:0]     cur_last;
  logic [31:0]     cur_pend;
  logic [15:0]     expect_seq;
  logic [15:0]     gap;
  logic [1:0]      cls;
  logic [14:0]     missing;
  logic            credited;

  assign src_ext    = IdxW'(item_i.source_index);
  assign idx        = src_ext[SrcW-1:0];
  assign src_ok     = (32'(item_i.source_index) < 32'(NumSources));
  assign cur_seen   = seen_q[idx];
  assign cur_last   = last_q[idx];
  assign cur_pend   = pend_q[idx];
  assign expect_seq = cur_last + 16'd1;
  assign gap        = item_i.sequence_number - expect_seq;

  always_comb begin
    for (int unsigned s = 0; s < NumSources; s++) begin
      seen_d[s] = seen_q[s];
      last_d[s] = last_q[s];
      pend_d[s] = pend_q[s];
    end
    frames_d     = frames_q;
    gap_events_d = gap_events_q;
    gap_frames_d = gap_frames_q;
    reordered_d  = reordered_q;
    recovered_d  = recovered_q;
    cls          = CLS_FIRST;
    missing      = '0;
    credited     = 1'b0;

    unique case (item_i.operation)
      OP_ACCEPT: begin
        if (src_ok) begin
          frames_d = sat_add32(frames_q, 32'd1);
          if (!cur_seen) begin
            seen_d[idx] = 1'b1;
            last_d[idx] = item_i.sequence_number;
            cls         = CLS_FIRST;
          end else if (item_i.sequence_number == expect_seq) begin
            last_d[idx] = item_i.sequence_number;
            cls         = CLS_IN_ORDER;
          end else if (!gap[15]) begin
            cls          = CLS_GAP;
            missing      = gap[14:0];
            gap_events_d = sat_add32(gap_events_q, 32'd1);
            gap_frames_d = sat_add32(gap_frames_q, 32'(gap));
            pend_d[idx]  = sat_add32(cur_pend, 32'(gap));
            last_d[idx]  = item_i.sequence_number;
          end else begin
            cls         = CLS_REORDERED;
            reordered_d = sat_add32(reordered_q, 32'd1);
          end
        end
      end
      OP_CREDIT: begin
        if (src_ok && item_i.queue_ok && (cur_pend != '0)) begin
          pend_d[idx] = cur_pend - 32'd1;
          recovered_d = sat_add32(recovered_q, 32'd1);
          credited    = 1'b1;
        end
      end
      OP_CLEAR_SOURCE: begin
        if (src_ok) begin
          seen_d[idx] = 1'b0;
          last_d[idx] = '0;
          pend_d[idx] = '0;
        end
      end
      OP_CLEAR_SOURCES, OP_CLEAR_ALL: begin
        for (int unsigned s = 0; s < NumSources; s++) begin
          seen_d[s] = 1'b0;
          last_d[s] = '0;
          pend_d[s] = '0;
        end
        if (item_i.operation == OP_CLEAR_ALL) begin
          frames_d     = '0;
          gap_events_d = '0;
          gap_frames_d = '0;
          reordered_d  = '0;
          recovered_d  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned s = 0; s < NumSources; s++) begin
        seen_q[s] <= 1'b0;
        last_q[s] <= '0;
        pend_q[s] <= '0;
      end
      frames_q     <= '0;
      gap_events_q <= '0;
      gap_frames_q <= '0;
      reordered_q  <= '0;
      recovered_q  <= '0;
    end else if (exec_i) begin
      for (int unsigned s = 0; s < NumSources; s++) begin
        seen_q[s] <= seen_d[s];
        last_q[s] <= last_d[s];
        pend_q[s] <= pend_d[s];
      end
      frames_q     <= frames_d;
      gap_events_q <= gap_events_d;
      gap_frames_q <= gap_frames_d;
      reordered_q  <= reordered_d;
      recovered_q  <= recovered_d;
    end
  end

  always_comb begin
    result_o.frame_class      = cls;
    result_o.missing_frames   = missing;
    result_o.credited         = credited;
    result_o.total_frames     = frames_d;
    result_o.total_gap_events = gap_events_d;
    result_o.total_gap_frames = gap_frames_d;
    result_o.total_reordered  = reordered_d;
    result_o.total_recovered  = recovered_d;
  end

endmodule

// File: rtl/per_source_sequence_gap_tracker.sv
// Top level of the per-source sequence gap tracker.
// Input register, state table instance and result register with handshakes.
// Depends on psgt_pkg and psgt_track.
//
// Usage: items arrive on the input channel (in_valid_i, in_ready_o, in_data_i)
// and each produces exactly one result on the output channel (out_valid_o,
// out_ready_i, out_data_o). Operations are frame accept, gap credit, clear of
// one source, clear of all sources, and clear of sources and totals.
// An accepted item is loaded into the input register; when the result register
// is free or being drained, the table state updates and the result register loads.
// Throughput is one item per cycle while the receiver keeps up, with the
// per-source table and the saturating totals read, modified and written back.
// When the receiver stalls, the result register holds its transfer and the
// input register keeps one more item; in_ready_o drops once both are full.
// Reset clears all per-source state, all totals and both valid flags; the
// block accepts an item in the first cycle after reset.
module per_source_sequence_gap_tracker #(
  parameter int unsigned NumSources = psgt_pkg::NumSourcesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psgt_pkg::psgt_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psgt_pkg::psgt_out_t out_data_o
);
  import psgt_pkg::*;

  logic      in_valid_q;
  psgt_in_t  in_q;
  logic      out_valid_q;
  psgt_out_t out_q;
  psgt_out_t result;
  logic      exec;

  assign exec       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || exec;

  psgt_track #(
    .NumSources(NumSources)
  ) u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .exec_i  (exec),
    .item_i  (in_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (exec) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
